### rtl/stack_region_allocator_assert.svh
// ----------------------------------------------------------------------------
// Stack region allocator assertion macros
// Shared concurrent assertion templates used by the checker.
// ----------------------------------------------------------------------------
`ifndef STACK_REGION_ALLOCATOR_ASSERT_SVH
`define STACK_REGION_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/sra_pkg.sv
// ----------------------------------------------------------------------------
// Stack region allocator package
// Sizes, request and status codes, and the control structs of the stack.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int unsigned POOL_BYTES   = 16777216;
  localparam int unsigned RECORD_DEPTH = 64;
  // Alignment must be a power of two.
  localparam int unsigned ALIGN_BYTES  = 32;

  localparam int unsigned ADDR_W   = $clog2(POOL_BYTES);
  localparam int unsigned TOP_W    = ADDR_W + 1;
  localparam int unsigned LEN_W    = 25;
  localparam int unsigned RND_W    = LEN_W + 1;
  localparam int unsigned SUM_W    = RND_W + 1;
  localparam int unsigned CNT_W    = $clog2(RECORD_DEPTH + 1);
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STAT_W   = 2;

  localparam int unsigned S_TDATA_W = ((LEN_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((ADDR_W + TOP_W + 7) / 8) * 8;

  localparam logic [TOP_W-1:0] POOL_TOP   = TOP_W'(POOL_BYTES);
  localparam logic [SUM_W-1:0] POOL_SUM   = SUM_W'(POOL_BYTES);
  localparam logic [RND_W-1:0] ALIGN_M1   = RND_W'(ALIGN_BYTES - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(RECORD_DEPTH);

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_RESET = 2'd2
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NO_RECORD = 2'd2
  } status_e;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [ADDR_W-1:0] push_data;
  } stack_ctrl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [ADDR_W-1:0] head;
  } stack_stat_t;

endpackage

### rtl/sra_cell.sv
// ----------------------------------------------------------------------------
// Stack region allocator record cell
// One entry of the shifting record stack.
// ----------------------------------------------------------------------------
module sra_cell (
  input  logic                       clk_i,
  input  logic                       push_i,
  input  logic                       pop_i,
  input  logic [sra_pkg::ADDR_W-1:0] prev_i,
  input  logic [sra_pkg::ADDR_W-1:0] next_i,
  output logic [sra_pkg::ADDR_W-1:0] data_o
);
  import sra_pkg::*;

  logic [ADDR_W-1:0] data_q;
  logic [ADDR_W-1:0] data_d;

  // A push takes the newer neighbor's entry, a pop the older neighbor's.
  always_comb begin
    data_d = data_q;
    if (push_i) begin
      data_d = prev_i;
    end else if (pop_i) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/sra_stack.sv
// ----------------------------------------------------------------------------
// Stack region allocator record stack
// A row of cells with the newest record in cell zero, plus the fill count.
// ----------------------------------------------------------------------------
module sra_stack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sra_pkg::stack_ctrl_t ctrl_i,
  output sra_pkg::stack_stat_t stat_o
);
  import sra_pkg::*;

  logic [ADDR_W-1:0] cell_data [RECORD_DEPTH];
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_d;

  for (genvar i = 0; i < RECORD_DEPTH; i++) begin : g_cell
    logic [ADDR_W-1:0] prev_data;
    logic [ADDR_W-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = ctrl_i.push_data;
    end else begin : g_mid
      assign prev_data = cell_data[i-1];
    end

    if (i == RECORD_DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_inner
      assign next_data = cell_data[i+1];
    end

    sra_cell u_cell (
      .clk_i  (clk_i),
      .push_i (ctrl_i.push),
      .pop_i  (ctrl_i.pop),
      .prev_i (prev_data),
      .next_i (next_data),
      .data_o (cell_data[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    priority if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (ctrl_i.push) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ctrl_i.pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == DEPTH_CNT);
  assign stat_o.head  = cell_data[0];

endmodule

### rtl/stack_region_allocator.sv
// ----------------------------------------------------------------------------
// Stack region allocator
// Bump allocator over a fixed pool with last-in first-out freeing.
// ----------------------------------------------------------------------------
// Each request is decoded, checked against the pool and applied to the top
// pointer and the record stack at the edge that accepts it, and its reply
// sits in the output register from the next cycle on. One request is
// accepted per cycle as long as the reply register is empty or being
// drained; the rate is set by the single add and compare on the top
// pointer and by the one-step shift of the record cell row. An allocate
// rounds its length up to the alignment; if the rounded length does not fit
// above the top it fails with status out of space and address 0, otherwise
// the old top is returned, the top advances, and the old top is pushed on
// the record stack unless that stack is full. A free pops the newest record
// and moves the top back to it, or reports no records. A reset request
// clears the top and the stack. Every reply carries the bytes left above
// the top. The stack needs no clearing pass after reset: only entries below
// the fill count are ever read.
// ----------------------------------------------------------------------------
module stack_region_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: length [24:0], zero padding above.
  input  logic [sra_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: req_type [1:0].
  input  logic [sra_pkg::REQ_W-1:0]     s_axis_tuser,
  // Reply channel.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: address [23:0], free_bytes [48:24], zero padding above.
  output logic [sra_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // tuser: status [1:0].
  output logic [sra_pkg::STAT_W-1:0]    m_axis_tuser
);
  import sra_pkg::*;

  logic              req_fire;
  logic [LEN_W-1:0]  req_len;
  logic [RND_W-1:0]  len_rounded;
  logic [SUM_W-1:0]  top_sum;

  logic [TOP_W-1:0]  top_q;
  logic [TOP_W-1:0]  top_d;

  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [ADDR_W-1:0] out_addr_d;
  logic [TOP_W-1:0]  out_free_q;
  logic [STAT_W-1:0] out_status_q;
  status_e           out_status_d;

  stack_ctrl_t       stk_ctrl;
  stack_stat_t       stk_stat;

  // The reply register frees up in the same cycle it is drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign req_fire      = s_axis_tvalid && s_axis_tready;

  // Round up to the alignment and add to the top, widened so nothing wraps.
  assign req_len     = s_axis_tdata[LEN_W-1:0];
  assign len_rounded = ({1'b0, req_len} + ALIGN_M1) & ~ALIGN_M1;
  assign top_sum     = {{(SUM_W-TOP_W){1'b0}}, top_q} + {1'b0, len_rounded};

  always_comb begin
    top_d              = top_q;
    out_addr_d         = '0;
    out_status_d       = ST_OK;
    stk_ctrl.push      = 1'b0;
    stk_ctrl.pop       = 1'b0;
    stk_ctrl.clear     = 1'b0;
    stk_ctrl.push_data = top_q[ADDR_W-1:0];
    if (req_fire) begin
      unique case (s_axis_tuser)
        REQ_ALLOC: begin
          if (top_sum > POOL_SUM) begin
            out_status_d = ST_NO_SPACE;
          end else begin
            // At a full pool a zero-length allocate returns the top's low bits.
            out_addr_d    = top_q[ADDR_W-1:0];
            top_d         = top_sum[TOP_W-1:0];
            stk_ctrl.push = !stk_stat.full;
          end
        end
        REQ_FREE: begin
          if (stk_stat.empty) begin
            out_status_d = ST_NO_RECORD;
          end else begin
            out_addr_d   = stk_stat.head;
            top_d        = {1'b0, stk_stat.head};
            stk_ctrl.pop = 1'b1;
          end
        end
        REQ_RESET: begin
          top_d          = '0;
          stk_ctrl.clear = 1'b1;
        end
        default: begin
          // Unused request code: plain status reply, no state change.
        end
      endcase
    end
  end

  sra_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (stk_ctrl),
    .stat_o (stk_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      top_q <= top_d;
      if (req_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Reply payload, loaded with the request that produced it.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      out_addr_q   <= out_addr_d;
      out_free_q   <= POOL_TOP - top_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-ADDR_W-TOP_W){1'b0}}, out_free_q, out_addr_q};
  assign m_axis_tuser  = out_status_q;

endmodule

### rtl/sra_checker.sv
// ----------------------------------------------------------------------------
// Stack region allocator port checker
// Watches the top level's ports and flags replies that cannot be right.
// ----------------------------------------------------------------------------
`include "stack_region_allocator_assert.svh"

module sra_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sra_pkg::REQ_W-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sra_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [sra_pkg::STAT_W-1:0]    m_axis_tuser
);
  import sra_pkg::*;

  logic              req_fire;
  logic              reply_stall;
  logic              reply_failed;
  logic [ADDR_W-1:0] reply_addr;
  logic [TOP_W-1:0]  reply_free;

  assign req_fire     = s_axis_tvalid && s_axis_tready;
  assign reply_stall  = m_axis_tvalid && !m_axis_tready;
  assign reply_failed = m_axis_tvalid &&
                        (m_axis_tuser == ST_NO_SPACE || m_axis_tuser == ST_NO_RECORD);
  assign reply_addr   = m_axis_tdata[ADDR_W-1:0];
  assign reply_free   = m_axis_tdata[ADDR_W+TOP_W-1:ADDR_W];

  // A stalled reply stays offered.
  `SRA_ASSERT_NEXT(a_reply_held, clk_i, rst_ni, reply_stall, m_axis_tvalid)

  // A failed request never hands out an address.
  `SRA_ASSERT_IMPL(a_fail_addr_zero, clk_i, rst_ni, reply_failed, reply_addr == '0)

  // The space left never exceeds the pool.
  `SRA_ASSERT_IMPL(a_free_in_pool, clk_i, rst_ni, m_axis_tvalid, reply_free <= POOL_TOP)

  // A reset request is answered next cycle with an empty pool and status ok.
  `SRA_ASSERT_NEXT(a_reset_reply, clk_i, rst_ni, req_fire && s_axis_tuser == REQ_RESET,
                   m_axis_tvalid && reply_free == POOL_TOP && m_axis_tuser == ST_OK)

endmodule

bind stack_region_allocator sra_checker u_sra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack region allocator testbench
// Sends allocate, free, reset and unused requests to the allocator while
// both streams stall at random. A scoreboard keeps its own copy of the top
// pointer and the record stack and checks every reply field by field.
// ----------------------------------------------------------------------------
module testbench;
  import sra_pkg::*;

  // The request field is two bits wide, but only three codes are defined.
  localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
  localparam int unsigned      MAX_REPORTS = 10;
  localparam int unsigned      RAND_ITEMS  = 1100;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [TOP_W-1:0]  free_bytes;
    logic [STAT_W-1:0] status;
  } reply_t;

  // Scoreboard: tracks the pool as requests are accepted and queues the
  // reply each one must produce. Replies come back in request order.
  class region_ledger;
    reply_t            pending_replies[$];
    logic [TOP_W-1:0]  top;
    int unsigned       depth_used;
    logic [ADDR_W-1:0] records[RECORD_DEPTH];
    int unsigned       mismatches;
    int unsigned       replies_seen;

    function new();
      top          = '0;
      depth_used   = 0;
      mismatches   = 0;
      replies_seen = 0;
    endfunction

    // Bytes still available above the top pointer.
    function longint unsigned space();
      return 64'(POOL_BYTES) - 64'(top);
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [LEN_W-1:0] len);
      longint unsigned rounded;
      reply_t          r;
      r.address = '0;
      r.status  = ST_OK;
      case (kind)
        REQ_ALLOC: begin
          rounded = ((64'(len) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
          if (64'(top) + rounded > 64'(POOL_BYTES)) begin
            r.status = ST_NO_SPACE;
          end else begin
            // Only the low address bits are returned and recorded, so a
            // zero-length allocate at a full pool reads back as address 0.
            r.address = top[ADDR_W-1:0];
            if (depth_used < RECORD_DEPTH) begin
              records[depth_used] = top[ADDR_W-1:0];
              depth_used++;
            end
            top = TOP_W'(64'(top) + rounded);
          end
        end
        REQ_FREE: begin
          if (depth_used == 0) begin
            r.status = ST_NO_RECORD;
          end else begin
            depth_used--;
            r.address = records[depth_used];
            top       = TOP_W'(r.address);
          end
        end
        REQ_RESET: begin
          top        = '0;
          depth_used = 0;
        end
        default: ;
      endcase
      r.free_bytes = TOP_W'(POOL_BYTES - 32'(top));
      pending_replies.push_back(r);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report($sformatf("reply %0d arrived with no request outstanding", replies_seen));
        return;
      end
      want = pending_replies.pop_front();
      if (got.address !== want.address)
        report($sformatf("reply %0d address: expected %h, got %h",
                         replies_seen, want.address, got.address));
      if (got.free_bytes !== want.free_bytes)
        report($sformatf("reply %0d free_bytes: expected %h, got %h",
                         replies_seen, want.free_bytes, got.free_bytes));
      if (got.status !== want.status)
        report($sformatf("reply %0d status: expected %0d, got %0d",
                         replies_seen, want.status, got.status));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [REQ_W-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]    m_axis_tuser;

  region_ledger ledger;

  // Idle state of the request side, kept across calls of send_request.
  int unsigned req_phase_left = 0;
  bit          req_steady     = 1'b0;

  stack_region_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Each side works in phases: some phases never idle, the others wait a
  // random number of cycles before every request or reply.
  function automatic int unsigned next_gap(inout int unsigned phase_left,
                                           inout bit steady);
    if (phase_left == 0) begin
      phase_left = $urandom_range(16, 64);
      steady     = ($urandom_range(0, 3) == 0);
    end
    phase_left--;
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  // Presents one request and returns at the edge that accepts it. Valid is
  // only lowered when a gap follows, so a back-to-back request keeps it high.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [LEN_W-1:0] len);
    int unsigned gap;
    gap = next_gap(req_phase_left, req_steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(len);
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ledger.note_request(kind, len);
  endtask

  // Reply side: the ready line stalls at random before every reply.
  initial begin
    int unsigned gap;
    int unsigned phase_left;
    bit          steady;
    phase_left = 0;
    steady     = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = next_gap(phase_left, steady);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Every reply accepted at an edge is checked against the oldest request.
  always @(posedge clk_i) begin
    reply_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.address    = m_axis_tdata[ADDR_W-1:0];
      got.free_bytes = m_axis_tdata[ADDR_W +: TOP_W];
      got.status     = m_axis_tuser;
      ledger.check_reply(got);
    end
  end

  initial begin
    int unsigned      n;
    int unsigned      pick;
    int unsigned      mode;
    int unsigned      burst_left;
    int unsigned      alloc_share;
    longint unsigned  room;
    longint unsigned  off;
    logic [REQ_W-1:0] kind;
    logic [LEN_W-1:0] len;

    ledger = new();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_ALLOC;
    rst_ni        <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: rounding, failures, an empty stack, a full pool with a
    // zero-length allocate on top, and the reset and unused request codes.
    send_request(REQ_RESET, '0);
    send_request(REQ_FREE, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, LEN_W'(1));
    send_request(REQ_ALLOC, LEN_W'(31));
    send_request(REQ_ALLOC, LEN_W'(33));
    send_request(REQ_ALLOC, '1);
    send_request(REQ_ALLOC, LEN_W'(POOL_BYTES));
    send_request(REQ_FREE, '0);
    send_request(REQ_FREE, '0);
    send_request(REQ_FREE, '0);
    send_request(REQ_FREE, '0);
    send_request(REQ_FREE, '1);
    send_request(REQ_UNUSED, '1);
    send_request(REQ_ALLOC, LEN_W'(POOL_BYTES));
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, LEN_W'(1));
    send_request(REQ_FREE, '0);
    send_request(REQ_FREE, '0);
    send_request(REQ_ALLOC, LEN_W'(POOL_BYTES - ALIGN_BYTES + 1));
    send_request(REQ_ALLOC, LEN_W'(25'h0AAAAAA));
    send_request(REQ_RESET, '1);
    send_request(REQ_ALLOC, LEN_W'(25'h0555555));
    send_request(REQ_RESET, '0);

    // Random part in bursts. Fill bursts allocate small regions almost
    // exclusively so the record stack reaches its depth; drain bursts pop
    // it empty and beyond; mixed bursts use every size, including lengths
    // that land right at the remaining space and lengths above the pool.
    burst_left = 0;
    mode       = 0;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 90);
        mode       = $urandom_range(0, 2);
      end
      burst_left--;
      alloc_share = (mode == 0) ? 92 : (mode == 1) ? 30 : 55;
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        kind = REQ_RESET;
      end else if (pick < 2) begin
        kind = REQ_UNUSED;
      end else if (pick < alloc_share) begin
        kind = REQ_ALLOC;
      end else begin
        kind = REQ_FREE;
      end

      room = ledger.space();
      pick = (mode == 0) ? $urandom_range(0, 49) : $urandom_range(0, 99);
      if (pick < 30) begin
        len = LEN_W'($urandom_range(0, 255));
      end else if (pick < 50) begin
        len = LEN_W'($urandom_range(256, 65535));
      end else if (pick < 65) begin
        len = LEN_W'($urandom_range(65536, 1 << 20));
      end else if (pick < 77) begin
        len = LEN_W'($urandom_range(1 << 20, 1 << 23));
      end else if (pick < 90) begin
        // Within a few alignment steps of an exact fit.
        off = $urandom_range(0, 80);
        len = (room + off >= 40) ? LEN_W'(room + off - 40) : '0;
      end else if (pick < 95) begin
        len = LEN_W'($urandom());
      end else begin
        len = '0;
      end
      send_request(kind, len);
    end
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding replies, then watch for stray ones.
    while (ledger.pending_replies.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (ledger.mismatches == 0 && ledger.pending_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sra_pkg.sv
rtl/sra_cell.sv
rtl/sra_stack.sv
rtl/stack_region_allocator.sv
rtl/sra_checker.sv
dv/testbench.sv
